FILE: rtl/core/bbc_pkg.sv
// Shared types, constants and helper functions of the bracket balance checker.
package bbc_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int CHAR_W = 16;
    localparam int POS_W = 16;
    localparam int STATUS_W = 3;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_ROUND = 2'd0;
    localparam kind_t KIND_SQUARE = 2'd1;
    localparam kind_t KIND_CURLY = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 16'h000A;
    localparam logic [CHAR_W-1:0] CH_OPEN_ROUND = 16'h0028;
    localparam logic [CHAR_W-1:0] CH_CLOSE_ROUND = 16'h0029;
    localparam logic [CHAR_W-1:0] CH_OPEN_SQUARE = 16'h005B;
    localparam logic [CHAR_W-1:0] CH_CLOSE_SQUARE = 16'h005D;
    localparam logic [CHAR_W-1:0] CH_OPEN_CURLY = 16'h007B;
    localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY = 16'h007D;

    localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STRAY_CLOSE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_KIND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OPEN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVER = 3'd4;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } char_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    fail_row;
        logic [POS_W-1:0]    fail_column;
    } result_item_t;

    typedef struct packed {
        logic  push;
        logic  pop;
        logic  clr;
        kind_t kind;
    } stack_cmd_t;

    typedef struct packed {
        logic  is_open;
        logic  is_close;
        logic  is_nl;
        kind_t kind;
    } char_class_t;

    function automatic char_class_t classify(input logic [CHAR_W-1:0] code);
        char_class_t c;
        c = '0;
        case (code)
            CH_NEWLINE:      c.is_nl = 1'b1;
            CH_OPEN_ROUND:
            begin
                c.is_open = 1'b1;
                c.kind = KIND_ROUND;
            end
            CH_OPEN_SQUARE:
            begin
                c.is_open = 1'b1;
                c.kind = KIND_SQUARE;
            end
            CH_OPEN_CURLY:
            begin
                c.is_open = 1'b1;
                c.kind = KIND_CURLY;
            end
            CH_CLOSE_ROUND:
            begin
                c.is_close = 1'b1;
                c.kind = KIND_ROUND;
            end
            CH_CLOSE_SQUARE:
            begin
                c.is_close = 1'b1;
                c.kind = KIND_SQUARE;
            end
            CH_CLOSE_CURLY:
            begin
                c.is_close = 1'b1;
                c.kind = KIND_CURLY;
            end
            default:         c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        return (v == POS_MAX) ? v : v + POS_W'(1);
    endfunction

endpackage

FILE: rtl/core/bbc_stack.sv
// Bracket kind stack: top in a register, lower entries in a synchronous memory.
module bbc_stack
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int CNT_W = $clog2(STACK_DEPTH + 1),
    localparam int ADDR_W = $clog2(STACK_DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  stack_cmd_t       cmd,
    output logic [CNT_W-1:0] count,
    output kind_t            top_kind
);

    kind_t mem [STACK_DEPTH];

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    kind_t             top_reg;
    kind_t             top_next;
    kind_t             rd_data_reg;
    kind_t             fwd_reg;
    logic              fwd_sel_reg;
    logic              fwd_sel_next;
    kind_t             second;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [CNT_W-1:0]  count_dec;
    logic [CNT_W-1:0]  rd_cnt;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clr)
        begin
            count_next = '0;
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        second = fwd_sel_reg ? fwd_reg : rd_data_reg;

        top_next = top_reg;
        if (cmd.push)
        begin
            top_next = cmd.kind;
        end
        else if (cmd.pop)
        begin
            top_next = second;
        end

        count_dec = count_reg - CNT_W'(1);
        wr_en = cmd.push && (count_reg != '0);
        wr_addr = count_dec[ADDR_W-1:0];
        rd_cnt = count_next - CNT_W'(2);
        rd_addr = rd_cnt[ADDR_W-1:0];
        fwd_sel_next = cmd.push && !cmd.clr;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= top_reg;
        end
        rd_data_reg <= mem[rd_addr];
        fwd_reg <= top_reg;
        top_reg <= top_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            fwd_sel_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            fwd_sel_reg <= fwd_sel_next;
        end
    end

    assign count = count_reg;
    assign top_kind = top_reg;

endmodule

FILE: rtl/core/bracket_balance_checker.sv
// Top level of the bracket balance checker: position tracking, error latch, result register.
//
//  Channel  | Direction | Handshake                  | Payload
//  char     | in        | char_valid / char_ready    | char_item   (char_code, last_char)
//  result   | out       | result_valid / result_ready| result_item (status, fail_row, fail_column)
//
//  One item per cycle unless a held result stalls the input; the result is registered and
//  appears in the cycle after its final item is taken.
//  The stack top sits in a register and the next entry is prefetched from the
//  synchronous stack memory, with a bypass after a push, so pushes and pops go back to back.
//  Reset sets the row and column counters to 1, clears the stack count and the error latch;
//  no memory clearing pass. char_ready drops only while a result is held and result_ready is low.
module bracket_balance_checker
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         char_valid,
    output logic         char_ready,
    input  char_item_t   char_item,
    output logic         result_valid,
    input  logic         result_ready,
    output result_item_t result_item
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    logic [CNT_W-1:0]    stack_cnt;
    kind_t               top_kind;
    stack_cmd_t          cmd;
    char_class_t         cls;
    logic                accept;

    logic [POS_W-1:0]    row_reg;
    logic [POS_W-1:0]    row_next;
    logic [POS_W-1:0]    col_reg;
    logic [POS_W-1:0]    col_next;
    logic [POS_W-1:0]    outer_row_reg;
    logic [POS_W-1:0]    outer_row_next;
    logic [POS_W-1:0]    outer_col_reg;
    logic [POS_W-1:0]    outer_col_next;
    logic [STATUS_W-1:0] err_reg;
    logic [STATUS_W-1:0] err_next;
    logic [POS_W-1:0]    err_row_reg;
    logic [POS_W-1:0]    err_row_next;
    logic [POS_W-1:0]    err_col_reg;
    logic [POS_W-1:0]    err_col_next;
    logic                result_valid_reg;
    logic                result_valid_next;
    result_item_t        result_reg;
    result_item_t        result_next;

    logic [POS_W-1:0]    row_cur;
    logic [POS_W-1:0]    col_cur;
    logic [CNT_W-1:0]    cnt_after;

    bbc_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .count   (stack_cnt),
        .top_kind(top_kind)
    );

    assign char_ready = !result_valid_reg || result_ready;
    assign accept = char_valid && char_ready;

    always_comb
    begin
        cls = classify(char_item.char_code);
        row_cur = cls.is_nl ? sat_inc(row_reg) : row_reg;
        col_cur = cls.is_nl ? '0 : col_reg;

        cmd = '0;
        row_next = row_reg;
        col_next = col_reg;
        outer_row_next = outer_row_reg;
        outer_col_next = outer_col_reg;
        err_next = err_reg;
        err_row_next = err_row_reg;
        err_col_next = err_col_reg;

        if (accept && (err_reg == ST_OK))
        begin
            row_next = row_cur;
            col_next = sat_inc(col_cur);
            if (cls.is_open)
            begin
                if (stack_cnt == CNT_W'(STACK_DEPTH))
                begin
                    err_next = ST_OVER;
                    err_row_next = outer_row_reg;
                    err_col_next = outer_col_reg;
                end
                else
                begin
                    if (stack_cnt == '0)
                    begin
                        outer_row_next = row_cur;
                        outer_col_next = col_cur;
                    end
                    cmd.push = 1'b1;
                    cmd.kind = cls.kind;
                end
            end
            else if (cls.is_close)
            begin
                if (stack_cnt == '0)
                begin
                    err_next = ST_STRAY_CLOSE;
                    err_row_next = row_cur;
                    err_col_next = col_cur;
                end
                else if (top_kind != cls.kind)
                begin
                    err_next = ST_KIND;
                    err_row_next = outer_row_reg;
                    err_col_next = outer_col_reg;
                end
                else
                begin
                    cmd.pop = 1'b1;
                end
            end
        end

        cnt_after = stack_cnt;
        if (cmd.push)
        begin
            cnt_after = stack_cnt + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            cnt_after = stack_cnt - CNT_W'(1);
        end

        if (err_next != ST_OK)
        begin
            result_next.status = err_next;
            result_next.fail_row = err_row_next;
            result_next.fail_column = err_col_next;
        end
        else if (cnt_after != '0)
        begin
            result_next.status = ST_OPEN;
            result_next.fail_row = outer_row_next;
            result_next.fail_column = outer_col_next;
        end
        else
        begin
            result_next.status = ST_OK;
            result_next.fail_row = '0;
            result_next.fail_column = '0;
        end

        result_valid_next = result_valid_reg && !result_ready;
        if (accept && char_item.last_char)
        begin
            result_valid_next = 1'b1;
            cmd.clr = 1'b1;
            row_next = POS_W'(1);
            col_next = POS_W'(1);
            outer_row_next = '0;
            outer_col_next = '0;
            err_next = ST_OK;
            err_row_next = '0;
            err_col_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= POS_W'(1);
            col_reg <= POS_W'(1);
            outer_row_reg <= '0;
            outer_col_reg <= '0;
            err_reg <= ST_OK;
            err_row_reg <= '0;
            err_col_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            outer_row_reg <= outer_row_next;
            outer_col_reg <= outer_col_next;
            err_reg <= err_next;
            err_row_reg <= err_row_next;
            err_col_reg <= err_col_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && char_item.last_char)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item = result_reg;

endmodule

FILE: rtl/core/bbc_checker.sv
// Port-level assertions for the bracket balance checker and their bind.
module bbc_checker
    import bbc_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         char_valid,
    input logic         char_ready,
    input char_item_t   char_item,
    input logic         result_valid,
    input logic         result_ready,
    input result_item_t result_item
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_item))
        else $error("result item changed while stalled");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !char_ready)
        else $error("input taken while result stalled");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_ready && char_item.last_char |=> result_valid)
        else $error("no result after final item");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_item.status == ST_OK
                          || result_item.status == ST_STRAY_CLOSE
                          || result_item.status == ST_KIND
                          || result_item.status == ST_OPEN
                          || result_item.status == ST_OVER))
        else $error("status code out of range");

    a_balanced_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.status == ST_OK |->
            result_item.fail_row == '0 && result_item.fail_column == '0)
        else $error("balanced result with nonzero position");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_item   (char_item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_item (result_item)
);
